// File: hw/rtl/fdll_pkg.sv
`default_nettype none

package fdll_pkg;

    localparam int BUFFER_DEPTH = 32768;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int POS_BITS     = 15;
    localparam int DELAY_BITS   = 31;
    localparam int ADDR_BITS    = $clog2(BUFFER_DEPTH);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [FRAC_BITS-1:0]          frac_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;

    // State of the clearing sweep that runs after reset.
    typedef struct packed {
        logic  busy;
        addr_t addr;
    } clr_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/fractional_delay_line_linear_unit.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// request  | s_valid / s_ready  | s_req_type, s_position, s_sample_in, s_delay_q16
// result   | m_valid / m_ready  | m_sample_out (read requests only)
//
// One request is taken per cycle while s_ready is high; a read result passes
// the registered memory read taken at the beat itself, the multiplier stage and
// the output register, in that order.
// Two copies of the sample memory are written alike so both taps read at once.
// After reset a clearing sweep zeroes all 32768 entries of the memory, one entry
// a cycle, with s_ready low. A stalled result holds its stage; earlier stages keep
// taking beats while they have room.
`default_nettype none

module fractional_delay_line_linear_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_req_type,
    input  wire logic        [fdll_pkg::POS_BITS-1:0]   s_position,
    input  wire logic signed [fdll_pkg::SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic        [fdll_pkg::DELAY_BITS-1:0] s_delay_q16,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [fdll_pkg::SAMPLE_BITS-1:0] m_sample_out
);

    import fdll_pkg::*;

    clr_status_t clr_status;
    logic        accept;
    logic        rd_accept;
    logic        wr_accept;
    addr_t       addr_a;
    addr_t       addr_b;
    logic        mem_wr_en;
    addr_t       mem_wr_addr;
    sample_t     mem_wr_data;
    sample_t     tap_a;
    sample_t     tap_b;
    logic        tap_valid_reg;
    frac_t       frac_reg;
    logic        tap_load;
    logic        interp_ready;

    assign tap_load  = !tap_valid_reg || interp_ready;
    assign s_ready   = tap_load && !clr_status.busy;
    assign accept    = s_valid && s_ready;
    assign rd_accept = accept && (s_req_type == REQ_READ);
    assign wr_accept = accept && (s_req_type == REQ_WRITE);

    // Tap a lies the integer delay back, tap b one entry further.
    assign addr_a = addr_t'(s_position) - s_delay_q16[FRAC_BITS +: ADDR_BITS];
    assign addr_b = addr_a - addr_t'(1);

    assign mem_wr_en   = clr_status.busy || wr_accept;
    assign mem_wr_addr = clr_status.busy ? clr_status.addr : addr_t'(s_position);
    assign mem_wr_data = clr_status.busy ? '0 : s_sample_in;

    fdll_clear u_clear (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr_status (clr_status)
    );

    fdll_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (rd_accept),
        .rd_addr (addr_a),
        .rd_data (tap_a)
    );

    fdll_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (rd_accept),
        .rd_addr (addr_b),
        .rd_data (tap_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_valid_reg <= 1'b0;
        end else if (tap_load) begin
            tap_valid_reg <= rd_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_accept) begin
            frac_reg <= s_delay_q16[FRAC_BITS-1:0];
        end
    end

    fdll_interp u_interp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (tap_valid_reg),
        .in_ready     (interp_ready),
        .in_a         (tap_a),
        .in_b         (tap_b),
        .in_frac      (frac_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    a_no_beat_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clr_status.busy |-> !s_ready
    ) else $error("request taken during clearing sweep");

    a_tap_from_read: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(tap_valid_reg) |-> $past(rd_accept)
    ) else $error("tap stage filled without a read beat");

    a_tap_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (tap_valid_reg && !interp_ready) |=>
            (tap_valid_reg && $stable(frac_reg) && $stable(tap_a) && $stable(tap_b))
    ) else $error("stalled tap stage changed");

endmodule

`default_nettype wire

// File: hw/rtl/fdll_ram.sv
`default_nettype none

module fdll_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fdll_clear.sv
`default_nettype none

module fdll_clear (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    output fdll_pkg::clr_status_t     clr_status
);

    import fdll_pkg::*;

    localparam addr_t LAST_ADDR = addr_t'(BUFFER_DEPTH - 1);

    logic  busy_reg, busy_next;
    addr_t addr_reg, addr_next;

    always_comb begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg) begin
            addr_next = addr_reg + addr_t'(1);
            if (addr_reg == LAST_ADDR) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign clr_status.busy = busy_reg;
    assign clr_status.addr = addr_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fdll_interp.sv
`default_nettype none

module fdll_interp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [fdll_pkg::SAMPLE_BITS-1:0] in_a,
    input  wire logic signed [fdll_pkg::SAMPLE_BITS-1:0] in_b,
    input  wire logic        [fdll_pkg::FRAC_BITS-1:0]   in_frac,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [fdll_pkg::SAMPLE_BITS-1:0] m_sample_out
);

    import fdll_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic                        prod_valid_reg;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    sample_t                     a_reg;
    logic                        out_valid_reg;
    sample_t                     out_reg, out_next;
    logic                        out_load;
    logic                        prod_load;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_W-1:0]    rounded;

    assign out_load  = !out_valid_reg || m_ready;
    assign prod_load = !prod_valid_reg || out_load;
    assign in_ready  = prod_load;

    always_comb begin
        diff      = {in_b[SAMPLE_BITS-1], in_b} - {in_a[SAMPLE_BITS-1], in_a};
        frac_s    = {1'b0, in_frac};
        prod_next = PROD_W'(diff) * PROD_W'(frac_s);
    end

    // The interpolated value always lies between a and b, so the low bits of
    // the rounded step added to a give the exact result.
    always_comb begin
        rounded  = prod_reg + ROUND_HALF;
        out_next = a_reg + rounded[FRAC_BITS +: SAMPLE_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_load) begin
                prod_valid_reg <= in_valid;
            end
            if (out_load) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_load && in_valid) begin
            prod_reg <= prod_next;
            a_reg    <= in_a;
        end
        if (out_load && prod_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_reg;

endmodule

`default_nettype wire
